/* design/tlfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfc_pkg
// Shared widths, byte codes, tag patterns and line type codes for the text
// line framer and classifier.
// ----------------------------------------------------------------------------
package tlfc_pkg;

  localparam int LINE_LIMIT = 4096;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 13;
  localparam int COMMA_W  = 12;
  localparam int TYPE_W   = 4;
  localparam int HEAD_W   = 40;
  localparam int TAIL_W   = 48;
  localparam int TLEN_W   = 3;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [LEN_W-1:0]   MAX_LEN_RESET = LEN_W'(1024);
  localparam logic [LEN_W-1:0]   LIMIT_MAX     = LEN_W'(LINE_LIMIT);
  localparam logic [COMMA_W-1:0] COMMA_MAX     = '1;

  localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_COMMA = 8'h2C;

  // Tag patterns, first character in the highest byte.
  localparam logic [HEAD_W-1:0] PAT_OK    = 40'h00_0000_4F4B;
  localparam logic [HEAD_W-1:0] PAT_ERR   = 40'h00_0045_5252;
  localparam logic [HEAD_W-1:0] PAT_WARN  = 40'h00_5741_524E;
  localparam logic [HEAD_W-1:0] PAT_DONE  = 40'h00_444F_4E45;
  localparam logic [HEAD_W-1:0] PAT_BOOT  = 40'h00_424F_4F54;
  localparam logic [HEAD_W-1:0] PAT_M0001 = 40'h4D_3030_3031;
  localparam logic [HEAD_W-1:0] PAT_M0004 = 40'h4D_3030_3034;
  localparam logic [TAIL_W-1:0] PAT_BEGIN = 48'h5F42_4547_494E;
  localparam logic [31:0]       PAT_END   = 32'h5F45_4E44;

  localparam logic [ADDR_W-1:0] REG_LINE_MAX = 3'd0;

  typedef enum logic [TYPE_W-1:0] {
    LT_UNKNOWN     = 4'd0,
    LT_OK          = 4'd1,
    LT_ERROR       = 4'd2,
    LT_WARNING     = 4'd3,
    LT_DONE        = 4'd4,
    LT_BOOT        = 4'd5,
    LT_KEY_EVENT   = 4'd6,
    LT_BLOCK_BEGIN = 4'd7,
    LT_BLOCK_END   = 4'd8,
    LT_DATA        = 4'd9
  } line_type_t;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [TAIL_W-1:0] tail;
    logic [TLEN_W-1:0] len;
  } tag_t;

endpackage

/* design/text_line_framer_classifier_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_framer_classifier_core
// Frames received bytes into LF-terminated lines and reports length, comma
// count and type of each non-empty line that is not discarded.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in       sink       in_valid / in_stall   in_rx_byte
//  out      source     out_valid / out_stall out_line_type, out_line_length,
//                                            out_comma_count
//  cfg      APB slave  psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// One byte is taken every cycle while in_stall is low; the line state
// updates at the edge that accepts the byte. A result enters the output
// register at the edge that accepts its LF, or the one-word skid register
// if the output is stalled; in_stall is high only while the skid is full.
// Synchronous active-low reset clears the line state, discard mode, both
// result registers and sets the line length limit to 1024.
// ----------------------------------------------------------------------------
module text_line_framer_classifier_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tlfc_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tlfc_pkg::TYPE_W-1:0]   out_line_type,
  output logic [tlfc_pkg::LEN_W-1:0]    out_line_length,
  output logic [tlfc_pkg::COMMA_W-1:0]  out_comma_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlfc_pkg::ADDR_W-1:0]   paddr,
  input  logic [tlfc_pkg::DATA_W-1:0]   pwdata,
  output logic [tlfc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import tlfc_pkg::*;

  function automatic tag_t tag_add(input tag_t t, input logic [BYTE_W-1:0] b);
    tag_t r;
    r = t;
    if (t.len < TLEN_W'(5)) begin
      r.head = {t.head[HEAD_W-BYTE_W-1:0], b};
    end
    r.tail = {t.tail[TAIL_W-BYTE_W-1:0], b};
    if (t.len != TLEN_W'(7)) begin
      r.len = t.len + TLEN_W'(1);
    end
    return r;
  endfunction

  function automatic line_type_t classify(input tag_t t, input logic has_comma);
    line_type_t r;
    if (t.len == TLEN_W'(0)) begin
      r = LT_UNKNOWN;
    end else if (t.len == TLEN_W'(2) && t.head == PAT_OK) begin
      r = LT_OK;
    end else if (t.len == TLEN_W'(3) && t.head == PAT_ERR) begin
      r = LT_ERROR;
    end else if (t.len == TLEN_W'(4) && t.head == PAT_WARN) begin
      r = LT_WARNING;
    end else if (t.len == TLEN_W'(4) && t.head == PAT_DONE) begin
      r = LT_DONE;
    end else if (t.len == TLEN_W'(4) && t.head == PAT_BOOT) begin
      r = LT_BOOT;
    end else if (t.len == TLEN_W'(5) && t.head >= PAT_M0001 && t.head <= PAT_M0004) begin
      r = LT_KEY_EVENT;
    end else if (t.len >= TLEN_W'(6) && t.tail == PAT_BEGIN) begin
      r = LT_BLOCK_BEGIN;
    end else if (t.len >= TLEN_W'(4) && t.tail[31:0] == PAT_END) begin
      r = LT_BLOCK_END;
    end else if (has_comma) begin
      r = LT_DATA;
    end else begin
      r = LT_UNKNOWN;
    end
    return r;
  endfunction

  localparam tag_t TAG_EMPTY = '{head: '0, tail: '0, len: '0};

  // Configuration.
  logic [LEN_W-1:0] max_len_r;
  logic             cfg_sel;
  logic             cfg_wr;

  assign cfg_sel = (paddr[ADDR_W-1:2] == REG_LINE_MAX[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && cfg_sel;
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? DATA_W'(max_len_r) : '0;

  // Line state.
  logic               discard_r,   discard_nxt;
  logic [LEN_W-1:0]   count_r,     count_nxt;
  logic [COMMA_W-1:0] commas_r,    commas_nxt;
  tag_t               tag_r,       tag_nxt;
  logic               tag_open_r,  tag_open_nxt;
  logic               cr_pend_r,   cr_pend_nxt;

  // Result and skid registers.
  logic               out_valid_r,  out_valid_nxt;
  line_type_t         out_type_r,   out_type_nxt;
  logic [LEN_W-1:0]   out_len_r,    out_len_nxt;
  logic [COMMA_W-1:0] out_commas_r, out_commas_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  line_type_t         skid_type_r,  skid_type_nxt;
  logic [LEN_W-1:0]   skid_len_r,   skid_len_nxt;
  logic [COMMA_W-1:0] skid_commas_r, skid_commas_nxt;

  logic               in_fire;
  logic               out_fire;
  logic               res_valid;
  line_type_t         res_type;
  logic [LEN_W-1:0]   res_len;
  logic [LEN_W-1:0]   limit;
  tag_t               tag_cr;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  always_comb begin
    if (max_len_r == '0) begin
      limit = LEN_W'(1);
    end else if (max_len_r > LIMIT_MAX) begin
      limit = LIMIT_MAX;
    end else begin
      limit = max_len_r;
    end
  end

  assign res_len  = count_r - LEN_W'(cr_pend_r);
  assign res_type = classify(tag_r, commas_r != '0);
  // A CR held back earlier turns out to be inside the line once a later byte arrives.
  assign tag_cr   = (cr_pend_r && tag_open_r) ? tag_add(tag_r, BYTE_CR) : tag_r;

  always_comb begin
    discard_nxt  = discard_r;
    count_nxt    = count_r;
    commas_nxt   = commas_r;
    tag_nxt      = tag_r;
    tag_open_nxt = tag_open_r;
    cr_pend_nxt  = cr_pend_r;
    res_valid    = 1'b0;
    if (in_fire) begin
      if (in_rx_byte == BYTE_LF) begin
        res_valid    = !discard_r && (res_len != '0);
        discard_nxt  = 1'b0;
        count_nxt    = '0;
        commas_nxt   = '0;
        tag_nxt      = TAG_EMPTY;
        tag_open_nxt = 1'b1;
        cr_pend_nxt  = 1'b0;
      end else if (!discard_r) begin
        if (count_r >= limit) begin
          discard_nxt  = 1'b1;
          count_nxt    = '0;
          commas_nxt   = '0;
          tag_nxt      = TAG_EMPTY;
          tag_open_nxt = 1'b1;
          cr_pend_nxt  = 1'b0;
        end else begin
          count_nxt   = count_r + LEN_W'(1);
          tag_nxt     = tag_cr;
          cr_pend_nxt = 1'b0;
          if (in_rx_byte == BYTE_COMMA) begin
            tag_open_nxt = 1'b0;
            if (commas_r != COMMA_MAX) begin
              commas_nxt = commas_r + COMMA_W'(1);
            end
          end else if (in_rx_byte == BYTE_CR) begin
            cr_pend_nxt = 1'b1;
          end else if (tag_open_r) begin
            tag_nxt = tag_add(tag_cr, in_rx_byte);
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_type_nxt    = out_type_r;
    out_len_nxt     = out_len_r;
    out_commas_nxt  = out_commas_r;
    skid_valid_nxt  = skid_valid_r;
    skid_type_nxt   = skid_type_r;
    skid_len_nxt    = skid_len_r;
    skid_commas_nxt = skid_commas_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_valid_nxt  = 1'b1;
        out_type_nxt   = skid_type_r;
        out_len_nxt    = skid_len_r;
        out_commas_nxt = skid_commas_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_fire) begin
      out_valid_nxt  = res_valid;
      out_type_nxt   = res_type;
      out_len_nxt    = res_len;
      out_commas_nxt = commas_r;
    end else if (res_valid) begin
      skid_valid_nxt  = 1'b1;
      skid_type_nxt   = res_type;
      skid_len_nxt    = res_len;
      skid_commas_nxt = commas_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= MAX_LEN_RESET;
      discard_r    <= 1'b0;
      count_r      <= '0;
      commas_r     <= '0;
      tag_r        <= TAG_EMPTY;
      tag_open_r   <= 1'b1;
      cr_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        max_len_r <= pwdata[LEN_W-1:0];
      end
      discard_r    <= discard_nxt;
      count_r      <= count_nxt;
      commas_r     <= commas_nxt;
      tag_r        <= tag_nxt;
      tag_open_r   <= tag_open_nxt;
      cr_pend_r    <= cr_pend_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_type_r    <= out_type_nxt;
    out_len_r     <= out_len_nxt;
    out_commas_r  <= out_commas_nxt;
    skid_type_r   <= skid_type_nxt;
    skid_len_r    <= skid_len_nxt;
    skid_commas_r <= skid_commas_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_line_type   = out_type_r;
  assign out_line_length = out_len_r;
  assign out_comma_count = out_commas_r;

endmodule

/* bench/text_line_framer_classifier_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_framer_classifier_core_tb
// Self-checking bench for the line framer. A directed table covers every
// line type, CR handling, empty lines, discard mode and the line limit
// boundaries. It is followed by random lines under several line limits and
// handshake mixes. Every accepted word runs through a local line predictor,
// and each reported line is compared field by field in order.
// ----------------------------------------------------------------------------
module text_line_framer_classifier_core_tb;
  import tlfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int          HOLD_CYCLES  = 250;
  localparam int          RANDOM_ITEMS = 1000;
  localparam int          SETTLE       = 4;

  localparam int PHASE_LIMITS [8] = '{1024, 12, 0, 4096, 8191, 30, 0, 3};
  localparam int SEND_IDLE    [4] = '{0, 79, 0, 9};
  localparam int RECV_STALL   [4] = '{0, 0, 79, 9};

  // Tag patterns, first character in the highest byte.
  localparam logic [HEAD_W-1:0] TAG_OK    = "OK";
  localparam logic [HEAD_W-1:0] TAG_ERR   = "ERR";
  localparam logic [HEAD_W-1:0] TAG_WARN  = "WARN";
  localparam logic [HEAD_W-1:0] TAG_DONE  = "DONE";
  localparam logic [HEAD_W-1:0] TAG_BOOT  = "BOOT";
  localparam logic [HEAD_W-1:0] TAG_M0001 = "M0001";
  localparam logic [HEAD_W-1:0] TAG_M0004 = "M0004";
  localparam logic [TAIL_W-1:0] TAG_BEGIN = "_BEGIN";
  localparam logic [31:0]       TAG_END   = "_END";

  typedef struct packed {
    line_type_t         ltype;
    logic [LEN_W-1:0]   len;
    logic [COMMA_W-1:0] commas;
  } line_info_t;

  typedef struct {
    int         cfg;       // -1 keeps the current limit
    string      head;
    int         pad_n;
    logic [7:0] pad_b;
    string      tail;
    int         exp_n;     // -1 predicted, 0 no line, 1 the typed line
    line_type_t e_type;
    int         e_len;
    int         e_commas;
  } row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [TYPE_W-1:0]    out_line_type;
  logic [LEN_W-1:0]     out_line_length;
  logic [COMMA_W-1:0]   out_comma_count;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  text_line_framer_classifier_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_line_type   (out_line_type),
    .out_line_length (out_line_length),
    .out_comma_count (out_comma_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Predictor state.
  logic [LEN_W-1:0]   limit_reg;
  logic               discarding;
  logic [LEN_W-1:0]   held;
  logic [COMMA_W-1:0] commas;
  logic [HEAD_W-1:0]  head;
  logic [TAIL_W-1:0]  tail;
  logic [TLEN_W-1:0]  tag_len;
  logic               tag_open;
  logic               cr_held;

  line_info_t  pending_lines[$];
  logic [7:0]  line_bytes[$];
  row_t        rows[$];

  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_req;
  int          errors;
  int          lines_checked;
  int          bytes_sent;
  int          bytes_framed;
  int          cfg_writes;
  int          backpressure_cycles;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d lines outstanding", cycles,
               pending_lines.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void add_byte(input logic [7:0] b);
    line_bytes.insert(line_bytes.size(), b);
  endfunction

  function automatic void add_line(input line_info_t li);
    pending_lines.insert(pending_lines.size(), li);
  endfunction

  function automatic void clear_line();
    held     = '0;
    commas   = '0;
    head     = '0;
    tail     = '0;
    tag_len  = '0;
    tag_open = 1'b1;
    cr_held  = 1'b0;
  endfunction

  function automatic void tag_push(input logic [7:0] b);
    if (tag_len < 5) head = {head[HEAD_W-9:0], b};
    tail = {tail[TAIL_W-9:0], b};
    if (tag_len < 7) tag_len++;
  endfunction

  // Advances the line state by one accepted word and reports a finished line.
  function automatic void frame_byte(input logic [7:0] b, output bit got,
                                     output line_info_t li);
    logic [LEN_W-1:0] lim;
    logic [LEN_W-1:0] len;
    got = 1'b0;
    li  = '0;
    if (!discarding) bytes_framed++;
    if (b == BYTE_LF) begin
      len = held - LEN_W'(cr_held);
      if (!discarding && len != 0) begin
        got       = 1'b1;
        li.len    = len;
        li.commas = commas;
        if (tag_len == 0) li.ltype = LT_UNKNOWN;
        else if (tag_len == 2 && head == TAG_OK) li.ltype = LT_OK;
        else if (tag_len == 3 && head == TAG_ERR) li.ltype = LT_ERROR;
        else if (tag_len == 4 && head == TAG_WARN) li.ltype = LT_WARNING;
        else if (tag_len == 4 && head == TAG_DONE) li.ltype = LT_DONE;
        else if (tag_len == 4 && head == TAG_BOOT) li.ltype = LT_BOOT;
        else if (tag_len == 5 && head >= TAG_M0001 && head <= TAG_M0004)
          li.ltype = LT_KEY_EVENT;
        else if (tag_len >= 6 && tail == TAG_BEGIN) li.ltype = LT_BLOCK_BEGIN;
        else if (tag_len >= 4 && tail[31:0] == TAG_END) li.ltype = LT_BLOCK_END;
        else if (commas != 0) li.ltype = LT_DATA;
        else li.ltype = LT_UNKNOWN;
      end
      discarding = 1'b0;
      clear_line();
      return;
    end
    if (discarding) return;
    lim = (limit_reg == 0) ? LEN_W'(1) : (limit_reg > LIMIT_MAX ? LIMIT_MAX : limit_reg);
    if (held >= lim) begin
      clear_line();
      discarding = 1'b1;
      return;
    end
    held++;
    // A CR only joins the tag once a later word shows it was not trailing.
    if (cr_held && tag_open) tag_push(BYTE_CR);
    cr_held = 1'b0;
    if (b == BYTE_COMMA) begin
      tag_open = 1'b0;
      if (commas != COMMA_MAX) commas++;
    end else if (b == BYTE_CR) begin
      cr_held = 1'b1;
    end else if (tag_open) begin
      tag_push(b);
    end
  endfunction

  function automatic void add_row(input int cfg, input string h, input int pad_n,
                                  input logic [7:0] pad_b, input string t,
                                  input int exp_n, input line_type_t e_type,
                                  input int e_len, input int e_commas);
    row_t r;
    r.cfg      = cfg;
    r.head     = h;
    r.pad_n    = pad_n;
    r.pad_b    = pad_b;
    r.tail     = t;
    r.exp_n    = exp_n;
    r.e_type   = e_type;
    r.e_len    = e_len;
    r.e_commas = e_commas;
    rows.insert(rows.size(), r);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void put_word(input int n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(33, 126));
      if (c == BYTE_COMMA) c = "_";
      add_byte(c);
    end
  endfunction

  function automatic logic [7:0] field_char();
    int         pick;
    logic [7:0] c;
    pick = $urandom_range(0, 19);
    if (pick == 0) return BYTE_CR;
    c = (pick == 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
    return (c == BYTE_LF) ? 8'h0B : c;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit use_pred);
    bit         got;
    line_info_t li;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    frame_byte(b, got, li);
    if (got && use_pred) add_line(li);
  endtask

  task automatic send_all(input bit use_pred);
    foreach (line_bytes[i]) send_byte(line_bytes[i], use_pred);
    line_bytes.delete();
  endtask

  // Returns at a rising edge once every expected line is out and the core
  // has settled.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input int unsigned v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_LINE_MAX;
    pwdata  <= DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    limit_reg = LEN_W'(v);
    cfg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_line();
    int         kind;
    int         pick;
    string      known[5];
    known = '{"OK", "ERR", "WARN", "DONE", "BOOT"};
    kind  = $urandom_range(0, 12);
    if (kind == 11) begin
      // Raw noise over the full byte range, line feeds included.
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) != 0) add_byte(BYTE_LF);
      send_all(1'b1);
      return;
    end
    if (kind == 12) begin
      repeat ($urandom_range(1, 3)) add_byte(field_char());
      add_byte(BYTE_LF);
      send_all(1'b1);
      return;
    end
    case (kind)
      0, 1, 2, 3, 4: put_text(known[kind]);
      5: begin
        put_text("M000");
        add_byte(8'h30 + 8'($urandom_range(0, 9)));
      end
      6: begin
        put_word($urandom_range(0, 4));
        put_text("_BEGIN");
      end
      7: begin
        put_word($urandom_range(0, 4));
        put_text("_END");
      end
      8: ;
      9: put_word($urandom_range(1, 8));
      default: begin
        // Near miss on a known tag: one bit flipped.
        put_text(known[$urandom_range(0, 4)]);
        pick = $urandom_range(0, line_bytes.size() - 1);
        line_bytes[pick] = line_bytes[pick] ^ (8'h01 << $urandom_range(0, 7));
      end
    endcase
    repeat ($urandom_range(0, 3)) begin
      add_byte(BYTE_COMMA);
      repeat ($urandom_range(0, 5)) add_byte(field_char());
    end
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 45)) add_byte(field_char());
    end
    pick = $urandom_range(0, 19);
    if (pick >= 14 && pick <= 18) add_byte(BYTE_CR);
    if (pick == 18) add_byte(BYTE_CR);
    if (pick != 19) add_byte(BYTE_LF);
    send_all(1'b1);
  endtask

  // Output side: random stall, plus a long hold-off on request.
  initial begin
    int hold_ack;
    int hold_left;
    hold_ack  = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    line_info_t want;
    if (rst_n) begin
      if (in_valid && in_stall) backpressure_cycles++;
      if (out_valid && !out_stall) begin
        if (pending_lines.size() == 0) begin
          $error("unexpected line: type %0d length %0d commas %0d",
                 out_line_type, out_line_length, out_comma_count);
          errors++;
        end else begin
          want = pending_lines[0];
          pending_lines.delete(0);
          lines_checked++;
          if (out_line_type !== want.ltype) begin
            $error("line_type: expected %0d, got %0d", want.ltype, out_line_type);
            errors++;
          end
          if (out_line_length !== want.len) begin
            $error("line_length: expected %0d, got %0d", want.len, out_line_length);
            errors++;
          end
          if (out_comma_count !== want.commas) begin
            $error("comma_count: expected %0d, got %0d", want.commas, out_comma_count);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    line_info_t typed_line;
    int         base;
    int         lim;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_rx_byte          = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_req            = 0;
    errors              = 0;
    lines_checked       = 0;
    bytes_sent          = 0;
    bytes_framed        = 0;
    cfg_writes          = 0;
    backpressure_cycles = 0;
    cycles              = 0;
    limit_reg           = MAX_LEN_RESET;
    discarding          = 1'b0;
    clear_line();

    // Directed lines, starting from the reset limit of 1024.
    add_row(-1, "OK\n",         0, 0, "", 1, LT_OK,          2, 0);
    add_row(-1, "ERR,1,2\n",    0, 0, "", 1, LT_ERROR,       7, 2);
    add_row(-1, "WARN\r\n",     0, 0, "", 1, LT_WARNING,     4, 0);
    add_row(-1, "DONE,x\n",     0, 0, "", 1, LT_DONE,        6, 1);
    add_row(-1, "BOOT\n",       0, 0, "", 1, LT_BOOT,        4, 0);
    add_row(-1, "M0001,a\n",    0, 0, "", 1, LT_KEY_EVENT,   7, 1);
    add_row(-1, "M0004\n",      0, 0, "", 1, LT_KEY_EVENT,   5, 0);
    add_row(-1, "M0005\n",      0, 0, "", -1, LT_UNKNOWN,    0, 0);
    add_row(-1, "M0000,1\n",    0, 0, "", -1, LT_UNKNOWN,    0, 0);
    add_row(-1, "CFG_BEGIN,3\n", 0, 0, "", 1, LT_BLOCK_BEGIN, 11, 1);
    add_row(-1, "CFG_END\n",    0, 0, "", 1, LT_BLOCK_END,   7, 0);
    add_row(-1, ",a,b\n",       0, 0, "", 1, LT_UNKNOWN,     4, 2);
    add_row(-1, "\n",           0, 0, "", 0, LT_UNKNOWN,     0, 0);
    add_row(-1, "\r\n",         0, 0, "", 0, LT_UNKNOWN,     0, 0);
    add_row(-1, "O\rK\n",       0, 0, "", -1, LT_UNKNOWN,    0, 0);
    add_row(-1, "OK\r\r\n",     0, 0, "", -1, LT_UNKNOWN,    0, 0);
    add_row(-1, "", 2, 8'hFF, ",a\n",  -1, LT_UNKNOWN, 0, 0);
    add_row(-1, "id", 3, 8'h00, "\n",  -1, LT_UNKNOWN, 0, 0);
    // A register value above the hard limit is clamped to 4096 bytes.
    add_row(8191, "", 40, BYTE_COMMA, "\n", 1, LT_UNKNOWN, 40, 40);
    // A line may fill the limit exactly; one byte more sends it to discard.
    add_row(16, "", 16, "A", "\n",  1, LT_UNKNOWN, 16, 0);
    add_row(-1, "", 17, "A", "\n",  0, LT_UNKNOWN, 0, 0);
    add_row(-1, "OK\n",         0, 0, "", 1, LT_OK,          2, 0);
    // The trailing CR counts toward the limit but not the length.
    add_row(-1, "", 15, "A", "\r\n", 1, LT_UNKNOWN, 15, 0);
    add_row(-1, "", 16, "A", "\r\n", 0, LT_UNKNOWN, 0, 0);
    add_row(0, "A\n",           0, 0, "", 1, LT_UNKNOWN,     1, 0);
    add_row(-1, "AB\n",         0, 0, "", 0, LT_UNKNOWN,     0, 0);
    // Limit lowered below the bytes already held.
    add_row(5, "ABCD",          0, 0, "", -1, LT_UNKNOWN,    0, 0);
    add_row(2, "E\n",           0, 0, "", 0, LT_UNKNOWN,     0, 0);
    add_row(1024, "DONE\n",     0, 0, "", 1, LT_DONE,        4, 0);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].cfg >= 0) begin
        wait_idle();
        write_limit(rows[i].cfg);
      end
      put_text(rows[i].head);
      repeat (rows[i].pad_n) add_byte(rows[i].pad_b);
      put_text(rows[i].tail);
      send_all(rows[i].exp_n < 0);
      if (rows[i].exp_n == 1) begin
        typed_line.ltype  = rows[i].e_type;
        typed_line.len    = LEN_W'(rows[i].e_len);
        typed_line.commas = COMMA_W'(rows[i].e_commas);
        add_line(typed_line);
      end
    end

    base = bytes_sent;
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      send_idle_pct  = SEND_IDLE[ph % 4];
      recv_stall_pct = RECV_STALL[ph % 4];
      lim = (ph == 6) ? $urandom_range(1, 40) : PHASE_LIMITS[ph];
      write_limit(lim);
      if (ph == 0) begin
        // Hold the output off while short lines keep coming, so the core
        // fills up and pushes back on its input; then drain completely.
        wait_idle();
        hold_req++;
        repeat (40) begin
          put_word($urandom_range(1, 3));
          add_byte(BYTE_COMMA);
          put_word($urandom_range(1, 3));
          add_byte(BYTE_LF);
          send_all(1'b1);
        end
        wait_idle();
      end
      while (bytes_sent - base < RANDOM_ITEMS * (ph + 1) / 8) send_line();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d words (%0d framed); checked %0d lines across %0d limit writes,",
             bytes_sent, bytes_framed, lines_checked, cfg_writes);
    $display("four handshake mixes and %0d cycles of input back-pressure.",
             backpressure_cycles);
    if (errors == 0 && pending_lines.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
